FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// concurrent check, disabled while reset is high
`define LASQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds during reset
`define LASQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LASQ_ASSERT(lbl, clk, rst, prop, msg)
`define LASQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/lasq_pkg.sv
// ----------------------------------------------------------------------------
// lasq_pkg
// Shared types and codes of the linear array queue with search.
// ----------------------------------------------------------------------------
package lasq_pkg;

  localparam int WORD_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int QUEUE_D = 2;

  // command codes on the command port
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;

  // status codes on the status port
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // classified operation
  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_SRCH,
    OP_NOP
  } op_t;

  // one queued command
  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] word;
  } cmd_t;

  // execution unit states
  typedef enum logic [1:0] {
    EX_IDLE,
    EX_DEQ,
    EX_SRCH
  } ex_state_t;

endpackage

FILE: hw/rtl/lasq_ram.sv
// ----------------------------------------------------------------------------
// lasq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lasq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/lasq_front.sv
// ----------------------------------------------------------------------------
// lasq_front
// Command intake: takes a command beat, decodes it and hands it to the queue.
// ----------------------------------------------------------------------------
module lasq_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [lasq_pkg::CMD_W-1:0]           command,
  input  logic signed [lasq_pkg::WORD_W-1:0]   operand_value,
  input  logic                                 fifo_full,
  output logic                                 busy,
  output logic                                 push,
  output lasq_pkg::cmd_t                       push_data
);

  logic           stage_valid;
  logic           stage_valid_next;
  lasq_pkg::cmd_t stage_item;
  lasq_pkg::op_t  op_dec;
  logic           accept;

  // stall only while a decoded beat waits on a full queue
  assign busy      = stage_valid & fifo_full;
  assign accept    = start & ~busy;
  assign push      = stage_valid & ~fifo_full;
  assign push_data = stage_item;

  // command decode
  always_comb begin
    unique case (command)
      lasq_pkg::CMD_ENQ:  op_dec = lasq_pkg::OP_ENQ;
      lasq_pkg::CMD_DEQ:  op_dec = lasq_pkg::OP_DEQ;
      lasq_pkg::CMD_SRCH: op_dec = lasq_pkg::OP_SRCH;
      default:            op_dec = lasq_pkg::OP_NOP;
    endcase
  end

  // stage occupancy
  always_comb begin
    priority if (accept) begin
      stage_valid_next = 1'b1;
    end else if (push) begin
      stage_valid_next = 1'b0;
    end else begin
      stage_valid_next = stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.op   <= op_dec;
      stage_item.word <= operand_value;
    end
  end

endmodule

FILE: hw/rtl/lasq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lasq_cmd_fifo
// Short command queue between the intake and the execution unit.
// ----------------------------------------------------------------------------
module lasq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lasq_pkg::cmd_t push_data,
  input  logic           pop,
  output lasq_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int QD  = lasq_pkg::QUEUE_D;
  localparam int QPW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  lasq_pkg::cmd_t   entries [QD];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == QCW'(QD));
  assign empty    = (count == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/lasq_exec.sv
// ----------------------------------------------------------------------------
// lasq_exec
// Execution unit: owns head/tail state and the slot RAM, runs each command.
// ----------------------------------------------------------------------------
module lasq_exec #(
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 fifo_empty,
  input  lasq_pkg::cmd_t                       pop_data,
  output logic                                 pop,
  output logic                                 done,
  output logic [lasq_pkg::STAT_W-1:0]          status,
  output logic signed [lasq_pkg::WORD_W-1:0]   read_value,
  output logic [lasq_pkg::SLOT_W-1:0]          found_slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int WW = lasq_pkg::WORD_W;
  localparam int SW = lasq_pkg::SLOT_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  lasq_pkg::ex_state_t state;
  lasq_pkg::ex_state_t state_next;

  logic [AW-1:0]                  head;
  logic [AW-1:0]                  head_next;
  logic [AW-1:0]                  tail;
  logic [AW-1:0]                  tail_next;
  logic                           is_empty;
  logic                           is_empty_next;
  logic [AW-1:0]                  idx;
  logic [AW-1:0]                  idx_next;
  logic signed [WW-1:0]           word;
  logic signed [WW-1:0]           word_next;
  logic                           done_next;
  logic [lasq_pkg::STAT_W-1:0]    status_next;
  logic signed [WW-1:0]           read_value_next;
  logic [SW-1:0]                  found_slot_next;

  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [WW-1:0]                  wr_data;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic [WW-1:0]                  rd_data;
  logic                           hit;

  lasq_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // compare of the slot read last cycle
  assign hit = (rd_data == word);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lasq_pkg::EX_IDLE: begin
        if (!fifo_empty && !is_empty) begin
          if (pop_data.op == lasq_pkg::OP_DEQ) begin
            state_next = lasq_pkg::EX_DEQ;
          end else if (pop_data.op == lasq_pkg::OP_SRCH) begin
            state_next = lasq_pkg::EX_SRCH;
          end
        end
      end
      lasq_pkg::EX_DEQ: begin
        state_next = lasq_pkg::EX_IDLE;
      end
      lasq_pkg::EX_SRCH: begin
        if (hit || idx == tail) begin
          state_next = lasq_pkg::EX_IDLE;
        end
      end
      default: begin
        state_next = lasq_pkg::EX_IDLE;
      end
    endcase
  end

  // datapath and result outputs
  always_comb begin
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = head;
    wr_en           = 1'b0;
    wr_addr         = tail + 1'b1;
    wr_data         = pop_data.word;
    head_next       = head;
    tail_next       = tail;
    is_empty_next   = is_empty;
    idx_next        = idx;
    word_next       = word;
    done_next       = 1'b0;
    status_next     = status;
    read_value_next = read_value;
    found_slot_next = found_slot;
    unique case (state)
      lasq_pkg::EX_IDLE: begin
        if (!fifo_empty) begin
          pop             = 1'b1;
          word_next       = pop_data.word;
          status_next     = lasq_pkg::ST_OK;
          read_value_next = '0;
          found_slot_next = '0;
          unique case (pop_data.op)
            lasq_pkg::OP_ENQ: begin
              done_next = 1'b1;
              priority if (is_empty) begin
                // first word always lands in slot zero
                wr_en         = 1'b1;
                wr_addr       = '0;
                head_next     = '0;
                tail_next     = '0;
                is_empty_next = 1'b0;
              end else if (tail == LAST) begin
                status_next = lasq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                tail_next = tail + 1'b1;
              end
            end
            lasq_pkg::OP_DEQ: begin
              if (is_empty) begin
                done_next   = 1'b1;
                status_next = lasq_pkg::ST_EMPTY;
              end else begin
                rd_en = 1'b1;
              end
            end
            lasq_pkg::OP_SRCH: begin
              if (is_empty) begin
                done_next   = 1'b1;
                status_next = lasq_pkg::ST_EMPTY;
              end else begin
                rd_en    = 1'b1;
                idx_next = head;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      lasq_pkg::EX_DEQ: begin
        done_next       = 1'b1;
        read_value_next = rd_data;
        if (head == tail) begin
          // last word out, back to empty
          head_next     = '0;
          tail_next     = '0;
          is_empty_next = 1'b1;
        end else begin
          head_next = head + 1'b1;
        end
      end
      lasq_pkg::EX_SRCH: begin
        priority if (hit) begin
          done_next       = 1'b1;
          found_slot_next = SW'(idx);
        end else if (idx == tail) begin
          done_next   = 1'b1;
          status_next = lasq_pkg::ST_NOT_FOUND;
        end else begin
          idx_next = idx + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lasq_pkg::EX_IDLE;
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      is_empty <= is_empty_next;
      done     <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    word       <= word_next;
    status     <= status_next;
    read_value <= read_value_next;
    found_slot <= found_slot_next;
  end

endmodule

FILE: hw/rtl/linear_array_queue_with_search_unit.sv
// ----------------------------------------------------------------------------
// linear_array_queue_with_search_unit
// Linear array queue of signed words with enqueue, dequeue and search.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; each command
// gives exactly one result, shown with done high for one cycle, and the
// receiver must take it then. Commands pass an intake register and a
// two-entry queue, so busy rises only when both are full. The execution unit
// then completes enqueue, an unused command code and any command to an
// empty queue straight from its idle state; a dequeue reads the head slot
// and returns it from the dequeue state; a search looks at up to DEPTH slots
// from head, reading one slot a cycle through the single read port of the
// slot RAM. The slot RAM is never cleared: only slots already written are read.
`include "assert_macros.svh"

module linear_array_queue_with_search_unit #(
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lasq_pkg::CMD_W-1:0]           command,
  input  logic signed [lasq_pkg::WORD_W-1:0]   operand_value,
  output logic                                 done,
  output logic [lasq_pkg::STAT_W-1:0]          status,
  output logic signed [lasq_pkg::WORD_W-1:0]   read_value,
  output logic [lasq_pkg::SLOT_W-1:0]          found_slot
);

  logic           push;
  lasq_pkg::cmd_t push_data;
  logic           pop;
  lasq_pkg::cmd_t pop_data;
  logic           fifo_full;
  logic           fifo_empty;

  // command intake and decode
  lasq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .command       (command),
    .operand_value (operand_value),
    .fifo_full     (fifo_full),
    .busy          (busy),
    .push          (push),
    .push_data     (push_data)
  );

  // decoupling queue
  lasq_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  // execution unit with slot storage
  lasq_exec #(
    .DEPTH (DEPTH)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .found_slot (found_slot)
  );

  // checks
  `LASQ_ASSERT_ALWAYS(a_no_done_after_rst, clk, $past(rst) |-> !done, "done after reset")
  `LASQ_ASSERT(a_busy_needs_full, clk, rst, busy |-> fifo_full, "busy without full queue")
  `LASQ_ASSERT(a_slot_only_on_ok, clk, rst, (done && status != lasq_pkg::ST_OK) |-> (found_slot == '0), "slot on failure")
  `LASQ_ASSERT(a_value_only_on_ok, clk, rst, (done && read_value != '0) |-> (status == lasq_pkg::ST_OK), "value on failure")

endmodule
